/* src/pli_pkg.sv */
`default_nettype none

package pli_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned LEN_W       = $clog2(CAPACITY + 1);
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic do_insert;
    logic do_delete;
    logic emit_single;
    logic single_ok;
    logic dump_start;
    logic dump_emit;
  } pli_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_ok;
    logic del_ok;
    logic empty;
    logic dump_last;
    logic out_free;
  } pli_sts_t;

endpackage

`default_nettype wire

/* src/pli_ctrl.sv */
`default_nettype none

module pli_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [pli_pkg::FUNC_W-1:0]     in_func_i,
  output logic                           in_ready_o,
  input  pli_pkg::pli_sts_t              sts_i,
  output pli_pkg::pli_cmd_t              cmd_o
);
  import pli_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic state_q, state_d;
  logic accept;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
    accept     = in_valid_i && in_ready_o;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func_i)
            FUNC_INSERT: begin
              cmd_o.do_insert   = sts_i.ins_ok;
              cmd_o.emit_single = 1'b1;
              cmd_o.single_ok   = sts_i.ins_ok;
            end
            FUNC_DELETE: begin
              cmd_o.do_delete   = sts_i.del_ok;
              cmd_o.emit_single = 1'b1;
              cmd_o.single_ok   = sts_i.del_ok;
            end
            FUNC_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.emit_single = 1'b1;
                cmd_o.single_ok   = 1'b1;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d          = ST_DUMP;
              end
            end
            default: begin
              // unused code: reject, state untouched
              cmd_o.emit_single = 1'b1;
              cmd_o.single_ok   = 1'b0;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          if (sts_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> !in_ready_o)
    else $error("input taken during dump");

  a_dump_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.dump_emit && sts_i.dump_last) |=> (state_q == ST_IDLE))
    else $error("dump did not end after last entry");

  a_single_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.do_insert && cmd_o.do_delete))
    else $error("insert and delete in one cycle");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_single, cmd_o.dump_emit, cmd_o.dump_start}))
    else $error("conflicting output commands");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_single || cmd_o.dump_emit) |-> sts_i.out_free)
    else $error("result written over a pending one");

endmodule

`default_nettype wire

/* src/pli_dp.sv */
`default_nettype none

module pli_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [pli_pkg::POS_W-1:0]           in_pos_i,
  input  logic signed [pli_pkg::VAL_W-1:0]    in_value_i,
  input  pli_pkg::pli_cmd_t                   cmd_i,
  output pli_pkg::pli_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_ok_o,
  output logic                                out_has_value_o,
  output logic signed [pli_pkg::VAL_W-1:0]    out_element_o,
  output logic                                out_last_o
);
  import pli_pkg::*;

  logic signed [VAL_W-1:0] entries_q [CAPACITY];
  logic [LEN_W-1:0]        len_q;
  logic [IDX_W-1:0]        idx_q;

  logic                    out_valid_q;
  logic                    out_ok_q;
  logic                    out_hv_q;
  logic signed [VAL_W-1:0] out_elem_q;
  logic                    out_last_q;

  logic [POS_W-1:0] len_pos;
  logic             dump_last;

  assign len_pos   = POS_W'(len_q);
  assign dump_last = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;

  assign sts_o.ins_ok    = (len_q < LEN_W'(CAPACITY)) && (in_pos_i <= len_pos);
  assign sts_o.del_ok    = in_pos_i < len_pos;
  assign sts_o.empty     = (len_q == '0);
  assign sts_o.dump_last = dump_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // shift chain: each cell takes its neighbor, the new value, or holds
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int unsigned PREV = (k == 0) ? 0 : k - 1;
    localparam int unsigned NEXT = (k == CAPACITY - 1) ? k : k + 1;
    logic signed [VAL_W-1:0] cell_d;

    always_comb begin
      cell_d = entries_q[k];
      if (cmd_i.do_insert) begin
        if (POS_W'(k) == in_pos_i) begin
          cell_d = in_value_i;
        end else if (POS_W'(k) > in_pos_i) begin
          cell_d = entries_q[PREV];
        end
      end else if (cmd_i.do_delete && (POS_W'(k) >= in_pos_i)) begin
        cell_d = entries_q[NEXT];
      end
    end

    always_ff @(posedge clk_i) begin
      entries_q[k] <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.do_insert) begin
        len_q <= len_q + LEN_W'(1);
      end else if (cmd_i.do_delete) begin
        len_q <= len_q - LEN_W'(1);
      end
      if (cmd_i.dump_start) begin
        idx_q <= '0;
      end else if (cmd_i.dump_emit) begin
        idx_q <= dump_last ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_single || cmd_i.dump_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      out_ok_q   <= cmd_i.single_ok;
      out_hv_q   <= 1'b0;
      out_elem_q <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.dump_emit) begin
      out_ok_q   <= 1'b1;
      out_hv_q   <= 1'b1;
      out_elem_q <= entries_q[idx_q];
      out_last_q <= dump_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_ok_o        = out_ok_q;
  assign out_has_value_o = out_hv_q;
  assign out_element_o   = out_elem_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire

/* src/positional_list_insert_delete.sv */
// Channel  | Dir | tdata (low bit up)                       | tuser (low bit up) | tlast
// s_axis   | in  | func[1:0], position[9:2], value[41:10]   | -                  | -
// m_axis   | out | element[31:0]                            | ok, has_value      | last
//
// Insert, delete, unused codes, dump of an empty list: one result per transaction;
//   the whole shift of the cell chain happens in the cycle the transaction is taken.
// Dump: one result per entry, one per cycle if not stalled, input held until the last.
// A result sits in the output register; a new item is taken as soon as it drains.
// Reset clears the length, so the list starts empty; no clearing pass.
// A stalled m_axis holds the output register, the current dump step and the input.
`default_nettype none

module positional_list_insert_delete (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pli_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // func, position, value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pli_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // element
  output logic [pli_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // ok, has_value
  output logic                                m_axis_tlast
);
  import pli_pkg::*;

  pli_cmd_t cmd;
  pli_sts_t sts;

  logic [FUNC_W-1:0]       in_func;
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_ok;
  logic                    out_hv;
  logic signed [VAL_W-1:0] out_elem;

  assign in_func  = s_axis_tdata[FUNC_W-1:0];
  assign in_pos   = s_axis_tdata[FUNC_W+POS_W-1:FUNC_W];
  assign in_value = s_axis_tdata[FUNC_W+POS_W+VAL_W-1:FUNC_W+POS_W];

  pli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (in_func),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pli_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_pos_i        (in_pos),
    .in_value_i      (in_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_ok_o        (out_ok),
    .out_has_value_o (out_hv),
    .out_element_o   (out_elem),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_elem);
  assign m_axis_tuser = {out_hv, out_ok};

endmodule

`default_nettype wire

/* verif/positional_list_insert_delete_tb.sv */
`default_nettype none

module positional_list_insert_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_OPS  = 68;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic        ok;
    logic        has_value;
    logic [31:0] element;
    logic        last;
  } list_result_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    int                reps;
    bit                typed;
    logic              exp_ok;
  } op_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  positional_list_insert_delete i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // func, position, value
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // element
    .m_axis_tuser  (m_axis_tuser),   // ok, has_value
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // shadow copy of the list
  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               list_len;
  list_result_t     expected_q [$];

  int  mismatches;
  int  results_checked;
  int  n_insert, n_delete, n_dump, n_unused, n_rejected, peak_len, full_hits;
  bit  burst_mode;
  bit  hold_req;
  int  holds_done;

  task automatic list_apply(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val, input bit emit);
    list_result_t res;
    int i;
    res = '{ok: 1'b0, has_value: 1'b0, element: '0, last: 1'b1};
    case (func)
      FUNC_INSERT: begin
        n_insert++;
        if (list_len == CAPACITY) full_hits++;
        if (list_len < CAPACITY && int'(pos) <= list_len) begin
          for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
          res.ok = 1'b1;
        end
        if (list_len > peak_len) peak_len = list_len;
        if (emit) expected_q.push_back(res);
      end
      FUNC_DELETE: begin
        n_delete++;
        if (int'(pos) < list_len) begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          res.ok = 1'b1;
        end
        if (emit) expected_q.push_back(res);
      end
      FUNC_DUMP: begin
        n_dump++;
        res.ok = 1'b1;
        if (list_len == 0) begin
          if (emit) expected_q.push_back(res);
        end else begin
          for (i = 0; i < list_len; i++) begin
            res.has_value = 1'b1;
            res.element   = list_mem[i];
            res.last      = (i == list_len - 1);
            if (emit) expected_q.push_back(res);
          end
        end
      end
      default: begin
        n_unused++;
        if (emit) expected_q.push_back(res);
      end
    endcase
    if ((func == FUNC_INSERT || func == FUNC_DELETE || func == FUNC_UNUSED) && !res.ok)
      n_rejected++;
  endtask

  // drive one transaction and book its expected results on acceptance
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val, input bit typed, input logic exp_ok);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - FUNC_W - POS_W - VAL_W){1'b0}}, val, pos, func};
    do @(posedge clk_i); while (!s_axis_tready);
    list_apply(func, pos, val, !typed);
    if (typed)
      expected_q.push_back('{ok: exp_ok, has_value: 1'b0, element: '0, last: 1'b1});
  endtask

  function automatic op_row_t mk_row(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                     input logic [VAL_W-1:0] val, input int reps,
                                     input bit typed, input logic exp_ok);
    op_row_t r;
    r.func = func; r.pos = pos; r.val = val; r.reps = reps; r.typed = typed; r.exp_ok = exp_ok;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin : timeout_guard
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : result_sink
    int stall;
    list_result_t got, want;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        // long back-pressure so the block fills and stalls its input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 3);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got = '{ok: m_axis_tuser[0], has_value: m_axis_tuser[1], element: m_axis_tdata,
              last: m_axis_tlast};
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got ok=%b hv=%b el=%h last=%b",
                 $time, got.ok, got.has_value, got.element, got.last);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        check_field("ok", 32'(want.ok), 32'(got.ok));
        check_field("has_value", 32'(want.has_value), 32'(got.has_value));
        check_field("element", want.element, got.element);
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin : op_source
    op_row_t rows [$];
    int r, k, pick, ins_w, del_w;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    list_len = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list corner cases first, then build, fill to capacity and delete from both ends
    rows.push_back(mk_row(FUNC_DUMP,   8'd0,   32'd0,         1, 1, 1'b1));
    rows.push_back(mk_row(FUNC_DELETE, 8'd0,   32'hFFFF_FFFF, 1, 1, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd1,   32'd5,         1, 1, 1'b0));
    rows.push_back(mk_row(FUNC_UNUSED, 8'd255, 32'hFFFF_FFFF, 1, 1, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd0,   32'h7FFF_FFFF, 1, 1, 1'b1));
    rows.push_back(mk_row(FUNC_INSERT, 8'd1,   32'h8000_0000, 1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd0,   32'hFFFF_FFFF, 1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd1,   32'd0,         1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_DUMP,   8'hAA,  32'h5555_5555, 1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd255, 32'd1,         1, 1, 1'b0));
    rows.push_back(mk_row(FUNC_DELETE, 8'd255, 32'd0,         1, 1, 1'b0));
    rows.push_back(mk_row(FUNC_DELETE, 8'd4,   32'd0,         1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_DELETE, 8'd1,   32'd0,         1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd0,   32'h1000_0000, 13, 0, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd16,  32'hDEAD_BEEF, 1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_INSERT, 8'd0,   32'hCAFE_F00D, 1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_DUMP,   8'h55,  32'hAAAA_AAAA, 1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_DELETE, 8'd15,  32'd0,         1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_DELETE, 8'd0,   32'd0,         1, 0, 1'b0));
    rows.push_back(mk_row(FUNC_DUMP,   8'd0,   32'd0,         1, 0, 1'b0));

    foreach (rows[i])
      for (r = 0; r < rows[i].reps; r++)
        send_op(rows[i].func, rows[i].pos, rows[i].val + r, rows[i].typed, rows[i].exp_ok);

    for (k = 0; k < RANDOM_OPS; k++) begin
      hold_req   = hold_req || (k == 10);
      burst_mode = (k >= 10 && k < 25) || (k >= 45 && k < 60);
      // grow the list in the first half, shrink it in the second
      ins_w = (k < RANDOM_OPS / 2) ? 55 : 30;
      del_w = (k < RANDOM_OPS / 2) ? 25 : 50;
      pick  = $urandom_range(0, 99);
      if (pick < ins_w) func = FUNC_INSERT;
      else if (pick < ins_w + del_w) func = FUNC_DELETE;
      else if (pick < 95) func = FUNC_DUMP;
      else func = FUNC_UNUSED;
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 255));
      else if (func == FUNC_INSERT) pos = POS_W'($urandom_range(0, list_len));
      else if (func == FUNC_DELETE && list_len > 0) pos = POS_W'($urandom_range(0, list_len - 1));
      else pos = POS_W'($urandom_range(0, 255));
      send_op(func, pos, $urandom(), 1'b0, 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    burst_mode = 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts, %0d deletes, %0d dumps, %0d unused codes; %0d rejected.",
             n_insert, n_delete, n_dump, n_unused, n_rejected);
    $display("Checked %0d results; peak length %0d, %0d inserts on a full list, %0d long stall(s).",
             results_checked, peak_len, full_hits, holds_done);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    mismatches = 0; results_checked = 0; n_insert = 0; n_delete = 0; n_dump = 0;
    n_unused = 0; n_rejected = 0; peak_len = 0; full_hits = 0; holds_done = 0;
    burst_mode = 1'b0; hold_req = 1'b0;
  end

endmodule

`default_nettype wire

/* positional_list_insert_delete.f */
src/pli_pkg.sv
src/pli_ctrl.sv
src/pli_dp.sv
src/positional_list_insert_delete.sv
verif/positional_list_insert_delete_tb.sv
